// ----- rtl/core/sbph_pkg.sv -----
// ----------------------------------------------------------------------------
// sbph_pkg
// Types, constants and register map shared by the spectrum bar peak hold core.
// ----------------------------------------------------------------------------
package sbph_pkg;

   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int HEIGHT_BITS_DEF = 10;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 96;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 19;

   // power of two, pointers wrap freely
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int LEVEL_W  = 21;
   localparam int NUMER_W  = 26;   // (level + 100000) * height, divided by 16
   localparam int CPROD_W  = 21;   // index * width
   localparam int CDEN_W   = 11;   // sample count

   // 70000 = 16 * 4375; the low four bits are dropped, then
   // n / 4375 = (n * HRECIP) >> HRECIP_SH, exact for n < 2^26
   localparam int HQUOT_W   = 14;
   localparam int HRECIP_W  = 27;
   localparam int HRECIP_SH = 39;
   localparam logic [HRECIP_W-1:0] HRECIP   = 27'd125658472;
   localparam logic [LEVEL_W-1:0]  LVL_BIAS = 21'd100000;

   localparam logic [10:0] RST_SCREEN_WIDTH  = 11'd320;
   localparam logic [9:0]  RST_SCREEN_HEIGHT = 10'd240;
   localparam logic [10:0] RST_SAMPLE_COUNT  = 11'd256;
   localparam logic [18:0] RST_AMP_OFFSET    = 19'h6_7960;  // -100000
   localparam logic [10:0] RST_AMP_STEP      = 11'd500;
   localparam logic        RST_PIXELS_16BIT  = 1'b1;

   localparam logic [23:0] RGB565_RED    = 24'h00F800;
   localparam logic [23:0] RGB565_YELLOW = 24'h00FE40;
   localparam logic [23:0] RGB565_GREEN  = 24'h000640;
   localparam logic [23:0] RGB565_WHITE  = 24'h00FFFF;
   localparam logic [23:0] RGB888_RED    = 24'hFF0000;
   localparam logic [23:0] RGB888_YELLOW = 24'hFFC800;
   localparam logic [23:0] RGB888_GREEN  = 24'h00C800;
   localparam logic [23:0] RGB888_WHITE  = 24'hFFFFFF;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_SCREEN_WIDTH  = 3'd0,
      REG_SCREEN_HEIGHT = 3'd1,
      REG_SAMPLE_COUNT  = 3'd2,
      REG_AMP_OFFSET    = 3'd3,
      REG_AMP_STEP      = 3'd4,
      REG_PIXELS_16BIT  = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      CLASS_WEAK   = 2'd0,
      CLASS_MEDIUM = 2'd1,
      CLASS_STRONG = 2'd2
   } level_class_type;

   typedef struct packed {
      logic [10:0] screen_width;
      logic [9:0]  screen_height;
      logic [10:0] sample_count;
      logic [18:0] amp_offset;
      logic [10:0] amp_step;
      logic        pixels_16bit;
   } cfg_type;

   typedef struct packed {
      logic [NUMER_W-1:0] numer;
      logic [CPROD_W-1:0] cprod;
   } job_type;

endpackage

// ----- rtl/core/sbph_fifo.sv -----
// ----------------------------------------------------------------------------
// sbph_fifo
// Short job queue between the front pipeline and the back sequencer.
// ----------------------------------------------------------------------------
module sbph_fifo import sbph_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  job_type           push_job,
   input  logic              pop,
   output job_type           head_job,
   output logic              empty,
   output logic [QCNT_W-1:0] count
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = slot_ff[rd_ptr_ff];
   assign empty    = (count_ff == '0);
   assign count    = count_ff;

endmodule

// ----- rtl/core/sbph_front.sv -----
// ----------------------------------------------------------------------------
// sbph_front
// Accepts samples, forms the level and the scaled products, queues a job.
// ----------------------------------------------------------------------------
module sbph_front import sbph_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  clearing,
   input  logic [QCNT_W-1:0]     q_count,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [9:0] sample_index, [17:10] sample_code
   output logic                  push_valid,
   output job_type               push_job
);

   logic [9:0]         idx;
   logic [7:0]         code;
   logic [10:0]        count_m1;
   logic [9:0]         idx_c;
   logic [18:0]        amp_prod;
   logic [LEVEL_W-1:0] lvl_in;
   logic [19:0]        lvl_pos;
   logic [29:0]        numer_in;
   logic [CPROD_W-1:0] cprod_in;
   logic [QCNT_W:0]    occ;
   logic               accept;

   logic               s1_valid_ff;
   logic [LEVEL_W-1:0] s1_lvl_ff;
   logic [9:0]         s1_idx_ff;
   logic               s2_valid_ff;
   logic [29:0]        s2_numer_ff;
   logic [CPROD_W-1:0] s2_cprod_ff;

   assign idx      = req_tdata[9:0];
   assign code     = req_tdata[17:10];
   assign count_m1 = (cfg.sample_count == 11'd0) ? 11'd0 : cfg.sample_count - 11'd1;
   assign idx_c    = ({1'b0, idx} > count_m1) ? count_m1[9:0] : idx;
   assign amp_prod = {11'b0, code} * {8'b0, cfg.amp_step};
   assign lvl_in   = {{2{cfg.amp_offset[18]}}, cfg.amp_offset} + {2'b00, amp_prod} + LVL_BIAS;

   // a negative level clamps to a height of zero
   assign lvl_pos  = s1_lvl_ff[LEVEL_W-1] ? 20'd0 : s1_lvl_ff[19:0];
   assign numer_in = {10'b0, lvl_pos} * {20'b0, cfg.screen_height};
   assign cprod_in = {11'b0, s1_idx_ff} * {10'b0, cfg.screen_width};

   assign occ = (QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_ff) + (QCNT_W+1)'(s2_valid_ff);
   assign req_tready = !clearing && (occ < (QCNT_W+1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_lvl_ff <= lvl_in;
         s1_idx_ff <= idx_c;
      end
      if (s1_valid_ff) begin
         s2_numer_ff <= numer_in;
         s2_cprod_ff <= cprod_in;
      end
   end

   assign push_valid     = s2_valid_ff;
   assign push_job.numer = s2_numer_ff[29:4];
   assign push_job.cprod = s2_cprod_ff;

endmodule

// ----- rtl/core/sbph_div.sv -----
// ----------------------------------------------------------------------------
// sbph_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbph_div import sbph_pkg::*; #(
   parameter int NUM_W = CPROD_W,
   parameter int DEN_W = CDEN_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] den_ff;

   logic [DEN_W:0]   shift;
   logic [DEN_W:0]   diff;
   logic             ge;
   logic [DEN_W-1:0] rem_in;

   assign shift  = {rem_ff, quo_ff[NUM_W-1]};
   assign diff   = shift - {1'b0, den_ff};
   assign ge     = (shift >= {1'b0, den_ff});
   assign rem_in = ge ? diff[DEN_W-1:0] : shift[DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= numer;
         den_ff <= denom;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NUM_W-2:0], ge};
      end
   end

   assign busy = busy_ff;
   assign quot = quo_ff;

endmodule

// ----- rtl/core/sbph_back.sv -----
// ----------------------------------------------------------------------------
// sbph_back
// Divides, updates the per-column peak store and builds the bar descriptor.
// ----------------------------------------------------------------------------
module sbph_back import sbph_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_empty,
   input  job_type               q_head,
   output logic                  q_pop,
   output logic                  clearing,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CW       = $clog2(MAX_COLUMNS);
   localparam int PEAK_MAX = (1 << HEIGHT_BITS) - 1;
   localparam int PW       = (HEIGHT_BITS > 10) ? HEIGHT_BITS : 10;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_DONE
   } state_type;

   state_type              state_ff;
   logic [CW-1:0]          clr_addr_ff;
   logic [9:0]             pct_ff;
   logic [CW-1:0]          col_ff;
   logic [HEIGHT_BITS-1:0] peak_rd_ff;
   logic                   rsp_valid_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic [HQUOT_W-1:0]     h_quot_ff;

   logic [HEIGHT_BITS-1:0] peak_mem [MAX_COLUMNS];

   logic                   start;
   logic                   c_busy;
   logic [NUMER_W+HRECIP_W-1:0] h_prod;
   logic [CPROD_W-1:0]     c_quot;
   logic [10:0]            count_eff;
   logic [9:0]             h;
   logic [9:0]             pct_in;
   logic [CW-1:0]          col_in;
   logic                   out_free;
   logic [HEIGHT_BITS-1:0] store_val;
   logic                   raise;
   logic [HEIGHT_BITS-1:0] pk_new;
   logic                   mem_we;
   logic [CW-1:0]          mem_waddr;
   logic [HEIGHT_BITS-1:0] mem_wdata;
   logic [11:0]            pct_x3;
   level_class_type        cls;
   logic [23:0]            bar_color;
   logic [23:0]            peak_color;
   logic [PW-1:0]          pk_w;
   logic [PW-1:0]          h_w;
   logic                   pk_on_screen;
   logic [9:0]             peak_row;
   logic                   peak_vis;
   logic [RSP_DATA_W-1:0]  rsp_data_in;

   assign h         = cfg.screen_height;
   assign count_eff = (cfg.sample_count == 11'd0) ? 11'd1 : cfg.sample_count;
   assign start     = (state_ff == ST_IDLE) && !q_empty;
   assign q_pop     = start;
   assign clearing  = (state_ff == ST_CLEAR);

   // height quotient by reciprocal multiplication
   assign h_prod = {HRECIP_W'(0), q_head.numer} * {NUMER_W'(0), HRECIP};

   sbph_div #(
      .NUM_W (CPROD_W),
      .DEN_W (CDEN_W)
   ) u_cdiv (
      .clock (clock),
      .reset (reset),
      .start (start),
      .numer (q_head.cprod),
      .denom (count_eff),
      .busy  (c_busy),
      .quot  (c_quot)
   );

   assign pct_in = (h_quot_ff > HQUOT_W'(h)) ? h : h_quot_ff[9:0];
   assign col_in = (c_quot > CPROD_W'(MAX_COLUMNS - 1)) ? CW'(MAX_COLUMNS - 1)
                                                         : c_quot[CW-1:0];

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign store_val = (32'(pct_ff) > PEAK_MAX) ? HEIGHT_BITS'(PEAK_MAX)
                                               : HEIGHT_BITS'(pct_ff);
   assign raise     = store_val > peak_rd_ff;
   assign pk_new    = raise ? store_val : peak_rd_ff;

   assign mem_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_DONE) && out_free && raise);
   assign mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : col_ff;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : store_val;

   // class thresholds: pct > 2h/3 and pct > h/3, compared as 3*pct against 2h and h
   assign pct_x3 = {2'b00, pct_ff} + {1'b0, pct_ff, 1'b0};

   always_comb begin
      if (pct_x3 > {1'b0, h, 1'b0}) begin
         cls = CLASS_STRONG;
      end else if (pct_x3 > {2'b00, h}) begin
         cls = CLASS_MEDIUM;
      end else begin
         cls = CLASS_WEAK;
      end
      case (cls)
         CLASS_STRONG: bar_color = cfg.pixels_16bit ? RGB565_RED    : RGB888_RED;
         CLASS_MEDIUM: bar_color = cfg.pixels_16bit ? RGB565_YELLOW : RGB888_YELLOW;
         default:      bar_color = cfg.pixels_16bit ? RGB565_GREEN  : RGB888_GREEN;
      endcase
   end

   assign peak_color   = cfg.pixels_16bit ? RGB565_WHITE : RGB888_WHITE;
   assign pk_w         = PW'(pk_new);
   assign h_w          = PW'(h);
   assign pk_on_screen = (pk_w <= h_w);
   assign peak_row     = pk_on_screen ? 10'(h_w - pk_w) : 10'd0;
   assign peak_vis     = pk_on_screen && (pk_new != '0);

   assign rsp_data_in = {5'b0, peak_color, peak_vis, peak_row, bar_color, cls,
                         h - pct_ff, pct_ff, 10'(col_ff)};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + CW'(1);
               if (clr_addr_ff == CW'(MAX_COLUMNS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (!c_busy) begin
                  pct_ff   <= pct_in;
                  col_ff   <= col_in;
                  state_ff <= ST_READ;
               end
            end
            ST_READ: begin
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= rsp_data_in;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         h_quot_ff <= h_prod[HRECIP_SH+HQUOT_W-1:HRECIP_SH];
      end
      if (mem_we) begin
         peak_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_READ) begin
         peak_rd_ff <= peak_mem[col_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/core/spectrum_bar_peak_hold_core.sv -----
// ----------------------------------------------------------------------------
// spectrum_bar_peak_hold_core
// The back end serves one job at a time, paced by the column divider; the
// front takes samples while fewer than QUEUE_DEPTH jobs are pending.
// Reset is synchronous; afterwards the peak store is cleared one column per
// cycle with req_tready low; csr writes are taken anytime.
// ----------------------------------------------------------------------------
module spectrum_bar_peak_hold_core import sbph_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [9:0] sample_index, [17:10] sample_code
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [9:0] column, [19:10] bar_height, [29:20] bar_top_row, [31:30] level_class,
   // [55:32] bar_color, [65:56] peak_row, [66] peak_visible, [90:67] peak_color
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   cfg_type           cfg_ff;
   logic              clearing;
   logic              push_valid;
   job_type           push_job;
   logic              q_pop;
   logic              q_empty;
   job_type           q_head;
   logic [QCNT_W-1:0] q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.sample_count  <= RST_SAMPLE_COUNT;
         cfg_ff.amp_offset    <= RST_AMP_OFFSET;
         cfg_ff.amp_step      <= RST_AMP_STEP;
         cfg_ff.pixels_16bit  <= RST_PIXELS_16BIT;
      end else if (csr_we) begin
         case (csr_addr)
            REG_SCREEN_WIDTH:  cfg_ff.screen_width  <= csr_wdata[10:0];
            REG_SCREEN_HEIGHT: cfg_ff.screen_height <= csr_wdata[9:0];
            REG_SAMPLE_COUNT:  cfg_ff.sample_count  <= csr_wdata[10:0];
            REG_AMP_OFFSET:    cfg_ff.amp_offset    <= csr_wdata[18:0];
            REG_AMP_STEP:      cfg_ff.amp_step      <= csr_wdata[10:0];
            REG_PIXELS_16BIT:  cfg_ff.pixels_16bit  <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   sbph_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .clearing   (clearing),
      .q_count    (q_count),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   sbph_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (q_head),
      .empty    (q_empty),
      .count    (q_count)
   );

   sbph_back #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
